### rtl/core/orbrms_pkg.sv
// Shared types, widths and helpers for the overwrite ring buffer RMS meter.
// No dependencies; imported by every module of the block.
package orbrms_pkg;

    localparam int STORE_DEPTH      = 8192;
    localparam int MAX_LEVEL_WINDOW = 1024;
    localparam int QUEUE_DEPTH      = 2;     // power of two

    localparam int SAMPLE_W = 16;
    localparam int ACTION_W = 2;
    localparam int FILL_W   = 13;
    localparam int RMS_W    = 16;
    localparam int CFG_W    = 11;
    localparam int LEVEL_WINDOW_RESET = 1024;

    localparam int PTR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int N_W     = $clog2(MAX_LEVEL_WINDOW + 1);
    localparam int CMP_W   = (PTR_W > N_W) ? PTR_W : N_W;
    localparam int SQ_W    = 2 * SAMPLE_W - 1;
    localparam int SUM_W   = SQ_W + $clog2(MAX_LEVEL_WINDOW);
    localparam int MEAN_W  = SQ_W;
    localparam int ROOT_IW = MEAN_W + 1;
    localparam int SQRT_STEPS = (MEAN_W + 1) / 2;
    localparam int CNT_W   = $clog2(SUM_W + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 48;
    localparam int TUSER_OUT_W = 2;

    localparam logic [ROOT_IW-1:0] SQRT_BIT0 = ROOT_IW'(1) << (2 * (SQRT_STEPS - 1));

    typedef enum logic [ACTION_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LEVEL = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
        logic                burst;
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                sample_valid;
        logic                overwrote_oldest;
        logic [FILL_W-1:0]   fill_count;
        logic [RMS_W-1:0]    rms_level;
        logic                burst_end_out;
    } res_t;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
        return (wp >= rp) ? wp - rp : wp - rp + PTR_W'(STORE_DEPTH);
    endfunction

endpackage

### rtl/core/overwrite_ring_buffer_rms_meter.sv
// Overwrite-oldest audio ring buffer with an RMS level meter (top level).
// Depends on orbrms_pkg, orbrms_front, orbrms_back (which holds orbrms_calc).
//
// Input stream (s_*): one beat per command. s_tuser is the action (push, pop,
// clear, level), s_tdata the Q1.15 sample for a push, s_tlast the burst end
// mark that is echoed on m_tlast. Every command returns exactly one result beat.
// Output stream (m_*): sample_out, fill_count and rms_level in m_tdata, the
// sample_valid and overwrote_oldest flags in m_tuser.
// Config port (cfg_*): writes level_window; write it only while the block is idle.
// Commands pass through a two-entry queue, so input beats are taken while the
// back end works or while a result waits in the output register.
// Push and clear finish in B_IDLE; a pop adds B_POP for the registered memory
// read. A level request over n samples walks the memory and square-accumulates,
// then runs a restoring division and a square root; the back end takes no other
// command meanwhile. A push result is held in the command queue and then in the
// output register, on its way from the input beat to the result beat.
// Reset empties the queue, zeroes both pointers, drops any pending result and
// sets level_window to 1024; stored samples are not cleared. A stalled m_tready
// holds the result; the queue then fills and s_tready drops.
module overwrite_ring_buffer_rms_meter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [orbrms_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] sample_in
    input  logic [orbrms_pkg::ACTION_W-1:0]      s_tuser,   // [1:0] action
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] sample_out, [28:16] fill_count, [44:29] rms_level, [47:45] zero
    output logic [orbrms_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic [orbrms_pkg::TUSER_OUT_W-1:0]   m_tuser,   // [0] sample_valid, [1] overwrote_oldest
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [orbrms_pkg::CFG_W-1:0]         cfg_data
);
    import orbrms_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;

    orbrms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    orbrms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = TDATA_OUT_W'({res.rms_level, res.fill_count, res.sample_out});
    assign m_tuser = {res.overwrote_oldest, res.sample_valid};
    assign m_tlast = res.burst_end_out;

endmodule

### rtl/core/orbrms_front.sv
// Front end: accepts input beats, decodes the action and queues commands.
// Depends on orbrms_pkg.
module orbrms_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [orbrms_pkg::TDATA_IN_W-1:0]   s_tdata,
    input  logic [orbrms_pkg::ACTION_W-1:0]     s_tuser,
    input  logic                                s_tlast,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output orbrms_pkg::cmd_t                    cmd
);
    import orbrms_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              in_cmd;

    always_comb
    begin
        in_cmd.op     = op_t'(s_tuser);
        in_cmd.sample = s_tdata[SAMPLE_W-1:0];
        in_cmd.burst  = s_tlast;
    end

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/core/orbrms_calc.sv
// Level math: restoring divide of the square sum by the sample count,
// then a digit-by-digit integer square root. Depends on orbrms_pkg.
module orbrms_calc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [orbrms_pkg::SUM_W-1:0]    sum,
    input  logic [orbrms_pkg::N_W-1:0]      n,
    output logic                            done,
    output logic [orbrms_pkg::RMS_W-1:0]    root
);
    import orbrms_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DIV  = 3'b010,
        C_SQRT = 3'b100
    } calc_state_t;

    calc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [N_W-1:0]     rem_reg, rem_next;
    logic [N_W-1:0]     dn_reg, dn_next;
    logic [ROOT_IW-1:0] x_reg, x_next;
    logic [ROOT_IW-1:0] root_reg, root_next;
    logic [ROOT_IW-1:0] bit_reg, bit_next;

    logic [N_W:0]       rem_sh;
    logic               q_bit;
    logic [N_W-1:0]     rem_step;
    logic [SUM_W-1:0]   dvd_step;
    logic [ROOT_IW-1:0] trial;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        q_bit    = (rem_sh >= {1'b0, dn_reg});
        rem_step = q_bit ? N_W'(rem_sh - {1'b0, dn_reg}) : N_W'(rem_sh);
        dvd_step = {dvd_reg[SUM_W-2:0], q_bit};
        trial    = root_reg + bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dn_next    = dn_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = sum;
                    rem_next   = '0;
                    dn_next    = n;
                    cnt_next   = CNT_W'(SUM_W);
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    // quotient is complete in dvd_step; mean of squares fits MEAN_W
                    x_next     = ROOT_IW'(dvd_step[MEAN_W-1:0]);
                    root_next  = '0;
                    bit_next   = SQRT_BIT0;
                    cnt_next   = CNT_W'(SQRT_STEPS);
                    state_next = C_SQRT;
                end
            end
            C_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_next    = x_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dn_reg   <= dn_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = RMS_W'(root_reg);

endmodule

### rtl/core/orbrms_back.sv
// Back end: pointers, sample memory, level accumulation and the output register.
// Depends on orbrms_pkg and orbrms_calc.
module orbrms_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  orbrms_pkg::cmd_t                    cmd,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [orbrms_pkg::CFG_W-1:0]        cfg_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output orbrms_pkg::res_t                    res
);
    import orbrms_pkg::*;

    typedef enum logic [5:0] {
        B_IDLE      = 6'b000001,
        B_POP       = 6'b000010,
        B_LVL_RD    = 6'b000100,
        B_LVL_DRAIN = 6'b001000,
        B_LVL_CALC  = 6'b010000,
        B_LVL_OUT   = 6'b100000
    } back_state_t;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

    back_state_t         state_reg, state_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic [N_W-1:0]      cnt_reg, cnt_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic                burst_reg, burst_next;
    logic [RMS_W-1:0]    rms_reg, rms_next;
    logic [CFG_W-1:0]    win_reg;
    logic                out_valid_reg;
    res_t                res_reg, res_next;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_vld_reg, sq_vld_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                out_free, out_load;
    logic                wr_en, rd_en, lvl_issue, acc_clr, calc_start;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    wp_inc, rp_inc, push_rp, fill_now;
    logic                full_hit, empty;
    logic [N_W-1:0]      win_eff, n_sel;
    logic signed [2*SAMPLE_W-1:0] prod;
    logic                calc_done;
    logic [RMS_W-1:0]    calc_root;

    orbrms_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .sum   (sum_reg),
        .n     (n_reg),
        .done  (calc_done),
        .root  (calc_root)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        wp_inc   = ptr_next(wp_reg);
        rp_inc   = ptr_next(rp_reg);
        full_hit = (wp_inc == rp_reg);
        push_rp  = full_hit ? rp_inc : rp_reg;
        empty    = (wp_reg == rp_reg);
        fill_now = fill_of(wp_reg, rp_reg);
        // window of zero counts as one, large windows saturate
        if (win_reg == '0)
        begin
            win_eff = N_W'(1);
        end
        else if (32'(win_reg) > MAX_LEVEL_WINDOW)
        begin
            win_eff = N_W'(MAX_LEVEL_WINDOW);
        end
        else
        begin
            win_eff = N_W'(win_reg);
        end
        n_sel = (CMP_W'(fill_now) < CMP_W'(win_eff)) ? N_W'(fill_now) : win_eff;
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        burst_next = burst_reg;
        rms_next   = rms_reg;
        res_next   = res_reg;
        cmd_ready  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = rp_reg;
        lvl_issue  = 1'b0;
        acc_clr    = 1'b0;
        calc_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next                  = '0;
                    res_next.burst_end_out    = cmd.burst;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            if (out_free)
                            begin
                                cmd_ready                 = 1'b1;
                                out_load                  = 1'b1;
                                wr_en                     = 1'b1;
                                wp_next                   = wp_inc;
                                rp_next                   = push_rp;
                                res_next.overwrote_oldest = full_hit;
                                res_next.fill_count       = FILL_W'(fill_of(wp_inc, push_rp));
                            end
                        end
                        OP_POP:
                        begin
                            if (!empty)
                            begin
                                cmd_ready  = 1'b1;
                                rd_en      = 1'b1;
                                rp_next    = rp_inc;
                                burst_next = cmd.burst;
                                state_next = B_POP;
                            end
                            else if (out_free)
                            begin
                                // underrun: zero sample, valid low
                                cmd_ready = 1'b1;
                                out_load  = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (out_free)
                            begin
                                cmd_ready = 1'b1;
                                out_load  = 1'b1;
                                wp_next   = '0;
                                rp_next   = '0;
                            end
                        end
                        OP_LEVEL:
                        begin
                            if (!empty)
                            begin
                                cmd_ready  = 1'b1;
                                pos_next   = rp_reg;
                                cnt_next   = n_sel;
                                n_next     = n_sel;
                                burst_next = cmd.burst;
                                acc_clr    = 1'b1;
                                state_next = B_LVL_RD;
                            end
                            else if (out_free)
                            begin
                                cmd_ready = 1'b1;
                                out_load  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b0;
                        end
                    endcase
                end
            end
            B_POP:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    res_next                  = '0;
                    res_next.sample_out       = rd_data_reg;
                    res_next.sample_valid     = 1'b1;
                    res_next.fill_count       = FILL_W'(fill_now);
                    res_next.burst_end_out    = burst_reg;
                    state_next                = B_IDLE;
                end
            end
            B_LVL_RD:
            begin
                rd_en     = 1'b1;
                rd_addr   = pos_reg;
                lvl_issue = 1'b1;
                pos_next  = ptr_next(pos_reg);
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == N_W'(1))
                begin
                    state_next = B_LVL_DRAIN;
                end
            end
            B_LVL_DRAIN:
            begin
                // wait for the read and square stages to empty into the sum
                if (!rd_vld_reg && !sq_vld_reg)
                begin
                    calc_start = 1'b1;
                    state_next = B_LVL_CALC;
                end
            end
            B_LVL_CALC:
            begin
                if (calc_done)
                begin
                    rms_next   = calc_root;
                    state_next = B_LVL_OUT;
                end
            end
            B_LVL_OUT:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    res_next               = '0;
                    res_next.rms_level     = rms_reg;
                    res_next.fill_count    = FILL_W'(fill_now);
                    res_next.burst_end_out = burst_reg;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign prod = $signed(rd_data_reg) * $signed(rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            win_reg       <= CFG_W'(LEVEL_WINDOW_RESET);
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            sq_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            rd_vld_reg <= lvl_issue;
            sq_vld_reg <= rd_vld_reg;
            if (cfg_valid)
            begin
                win_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        n_reg     <= n_next;
        burst_reg <= burst_next;
        rms_reg   <= rms_next;
        // a waiting result holds until it is taken
        if (out_load)
        begin
            res_reg <= res_next;
        end
        sq_reg    <= prod[SQ_W-1:0];
        if (acc_clr)
        begin
            sum_reg <= '0;
        end
        else if (sq_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= cmd.sample;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
